// ----- design/utf8d_pkg.sv -----
// ----------------------------------------------------------------------------
// utf8d_pkg
// Types and constants shared by the UTF-8 stream decoder modules.
// ----------------------------------------------------------------------------
package utf8d_pkg;

	localparam int CP_W  = 21;
	localparam int LEN_W = 3;

	localparam logic [CP_W-1:0] REPL_RESET = 21'h00FFFD;

	// lead and continuation byte classes
	localparam logic [7:0] MASK_E0 = 8'hE0;
	localparam logic [7:0] MASK_F0 = 8'hF0;
	localparam logic [7:0] MASK_F8 = 8'hF8;
	localparam logic [7:0] MASK_C0 = 8'hC0;
	localparam logic [7:0] LEAD_2  = 8'hC0;
	localparam logic [7:0] LEAD_3  = 8'hE0;
	localparam logic [7:0] LEAD_4  = 8'hF0;
	localparam logic [7:0] CONT    = 8'h80;

	localparam logic [LEN_W-1:0] LEN_1 = 3'd1;
	localparam logic [LEN_W-1:0] LEN_2 = 3'd2;
	localparam logic [LEN_W-1:0] LEN_3 = 3'd3;
	localparam logic [LEN_W-1:0] LEN_4 = 3'd4;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       final_byte;
	} in_t;

	typedef struct packed {
		logic [CP_W-1:0]  code_point;
		logic             malformed;
		logic [LEN_W-1:0] bytes_used;
		logic             run_end;
	} out_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hold;
		logic last;
		logic out_full;
	} sts_t;

endpackage

// ----- design/utf8_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// UTF-8 byte stream to code point decoder with end-of-text handling.
// ----------------------------------------------------------------------------
// Input requests carry one text byte and an end-of-text flag; output requests
// carry a code point, a malformed flag, the bytes covered and a run-end flag
// on the last result a byte causes. Both channels use valid/stall.
// A byte that only extends an unfinished sequence is taken and gives nothing.
// A byte that completes a sequence (or ends the text) is taken, then input
// stalls while results are loaded into the output register one per cycle as
// it frees up, up to three when a cut short sequence at end of text is
// replayed. The first result is loaded once the controller is in decode.
// A result waits in the output register, so while the receiver stalls the
// block keeps taking held bytes, but a sequence's results only advance as the
// register is emptied. The replacement code point is written through
// cfg_we/cfg_data; the user must do this only while idle (not enforced). Reset
// empties the sequence store and sets the replacement to U+FFFD.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  utf8d_pkg::in_t              in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output utf8d_pkg::out_t             out_data,
	input  logic                        cfg_we,
	input  logic [utf8d_pkg::CP_W-1:0]  cfg_data
);
	import utf8d_pkg::*;

	cmd_t cmd;
	sts_t sts;

	utf8d_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	utf8d_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_stall (out_stall)
	);

	// a completing byte blocks input until its results are out
	a_decode_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture && !sts.hold |=> in_stall)
		else $error("input not stalled after completing byte");

	// last result of a run returns to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out && sts.last |=> !in_stall && out_valid && out_data.run_end)
		else $error("run end not followed by idle");

	// a result is never loaded over one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !out_valid || !out_stall)
		else $error("output register overwritten");

	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_data.bytes_used != 3'd0 && out_data.bytes_used <= 3'd4)
		else $error("bytes_used out of range");

endmodule

// ----- design/utf8d_dp.sv -----
// ----------------------------------------------------------------------------
// utf8d_dp
// Datapath: sequence store, decoder at the head of the store, replacement
// register and output register.
// ----------------------------------------------------------------------------
module utf8d_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  utf8d_pkg::cmd_t             cmd,
	output utf8d_pkg::sts_t             sts,
	input  utf8d_pkg::in_t              in_data,
	input  logic                        cfg_we,
	input  logic [utf8d_pkg::CP_W-1:0]  cfg_data,
	output utf8d_pkg::out_t             out_data,
	output logic                        out_valid,
	input  logic                        out_stall
);
	import utf8d_pkg::*;

	function automatic logic [LEN_W-1:0] lead_length(input logic [7:0] c);
		logic [LEN_W-1:0] len;
		len = LEN_1;
		if ((c & MASK_E0) == LEAD_2)      len = LEN_2;
		else if ((c & MASK_F0) == LEAD_3) len = LEN_3;
		else if ((c & MASK_F8) == LEAD_4) len = LEN_4;
		return len;
	endfunction

	function automatic logic is_cont(input logic [7:0] c);
		return (c & MASK_C0) == CONT;
	endfunction

	logic [7:0]       seq_q [4];
	logic [1:0]       held_q;
	logic [LEN_W-1:0] n_q;
	logic [CP_W-1:0]  repl_q;
	out_t             out_q;
	logic             out_valid_q;

	logic [7:0]       lead_in;
	logic [LEN_W-1:0] count_in;
	logic [7:0]       c;
	logic [LEN_W-1:0] len;
	logic             cont_bad;
	logic [CP_W-1:0]  value;
	logic [CP_W-1:0]  cp;
	logic [LEN_W-1:0] used;
	logic             bad;

	// hold decision for the byte on offer
	always_comb begin
		lead_in  = (held_q == 2'd0) ? in_data.text_byte : seq_q[0];
		count_in = {1'b0, held_q} + LEN_1;
		sts.hold = !in_data.final_byte && (lead_length(lead_in) > count_in);
		sts.last = (n_q == used);
		// output register can take a new result when empty or emptied this cycle
		sts.out_full = out_valid_q && out_stall;
	end

	// decode the sequence that starts at the head of the store
	always_comb begin
		c   = seq_q[0];
		len = lead_length(c);
		cont_bad = ((len >= LEN_2) && !is_cont(seq_q[1])) ||
		           ((len >= LEN_3) && !is_cont(seq_q[2])) ||
		           ((len == LEN_4) && !is_cont(seq_q[3]));
		case (len)
			LEN_2:   value = {10'd0, c[4:0], seq_q[1][5:0]};
			LEN_3:   value = {5'd0, c[3:0], seq_q[1][5:0], seq_q[2][5:0]};
			LEN_4:   value = {c[2:0], seq_q[1][5:0], seq_q[2][5:0], seq_q[3][5:0]};
			default: value = '0;
		endcase
		cp   = '0;
		used = LEN_1;
		bad  = 1'b0;
		if (!c[7]) begin
			cp = {13'd0, c};
		end else if (len == LEN_1 || len > n_q) begin
			// stray byte, or lead cut short at end of text
			cp  = repl_q;
			bad = 1'b1;
		end else if (cont_bad) begin
			cp   = repl_q;
			used = len;
			bad  = 1'b1;
		end else begin
			cp   = value;
			used = len;
		end
	end

	// sequence store: no reset, entries are read only once written
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			seq_q[held_q] <= in_data.text_byte;
		end else if (cmd.load_out) begin
			// drop the bytes just consumed
			case (used)
				LEN_1: begin
					seq_q[0] <= seq_q[1];
					seq_q[1] <= seq_q[2];
					seq_q[2] <= seq_q[3];
				end
				LEN_2: begin
					seq_q[0] <= seq_q[2];
					seq_q[1] <= seq_q[3];
				end
				LEN_3: begin
					seq_q[0] <= seq_q[3];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= 2'd0;
			n_q         <= '0;
			repl_q      <= REPL_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) repl_q <= cfg_data;
			if (cmd.capture) begin
				if (sts.hold) begin
					held_q <= held_q + 2'd1;
				end else begin
					held_q <= 2'd0;
					n_q    <= count_in;
				end
			end else if (cmd.load_out) begin
				n_q <= n_q - used;
			end
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.code_point <= cp;
			out_q.malformed  <= bad;
			out_q.bytes_used <= used;
			out_q.run_end    <= sts.last;
		end
	end

	assign out_data  = out_q;
	assign out_valid = out_valid_q;

endmodule

// ----- design/utf8d_ctrl.sv -----
// ----------------------------------------------------------------------------
// utf8d_ctrl
// Controller: takes bytes while idle, then steps out the results of a
// finished sequence one per cycle as the output register frees up.
// ----------------------------------------------------------------------------
module utf8d_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  utf8d_pkg::sts_t sts,
	output utf8d_pkg::cmd_t cmd
);
	import utf8d_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE   = 2'b01,
		S_DECODE = 2'b10
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		in_stall     = (state_q != S_IDLE);
		cmd.capture  = in_valid && (state_q == S_IDLE);
		cmd.load_out = (state_q == S_DECODE) && !sts.out_full;
		state_d      = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.capture && !sts.hold) state_d = S_DECODE;
			end
			S_DECODE: begin
				if (cmd.load_out && sts.last) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks utf8_stream_decoder against a cycle-free model of the decoder.
// A short directed set covers ASCII limits, all sequence lengths, stray and
// bad bytes, end-of-text replay and a decode equal to the replacement. Random
// text then follows: mostly well-formed sequences, with broken ones, noise and
// early ends of text mixed in, under three replacement settings, random idling
// on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
	import utf8d_pkg::*;

	localparam int CLK_PERIOD  = 8;
	localparam int CYCLE_LIMIT = 250000;
	localparam int MAX_REPORTS = 10;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	in_t              in_data = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	out_t             out_data;
	logic             cfg_we = 1'b0;
	logic [CP_W-1:0]  cfg_data = '0;

	// decoder model state
	logic [CP_W-1:0]  repl_cp = REPL_RESET;
	logic [7:0]       held_seq [3];
	int               held_n = 0;
	out_t             expected_cps [$];

	int tx_idle_max = 12;
	int rx_idle_max = 12;
	int rx_wait = 0;
	int hold_left = 0;
	int bytes_sent = 0;
	int cps_checked = 0;
	int mismatch_count = 0;
	int cycle_count = 0;

	utf8_stream_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic int seq_len(input logic [7:0] c);
		if ((c & MASK_E0) == LEAD_2) return int'(LEN_2);
		if ((c & MASK_F0) == LEAD_3) return int'(LEN_3);
		if ((c & MASK_F8) == LEAD_4) return int'(LEN_4);
		return int'(LEN_1);
	endfunction

	// model of one accepted byte: holds it or queues the code points it completes
	task automatic decode_byte(input logic [7:0] b, input logic fin);
		logic [7:0]      pending [4];
		out_t            res [3];
		logic [CP_W-1:0] v;
		logic            broken;
		int              count, need, pos, k, len, i;
		for (i = 0; i < held_n; i++)
			pending[i] = held_seq[i];
		pending[held_n] = b;
		count = held_n + 1;
		need = seq_len(pending[0]);
		if (!fin && need > count) begin
			held_seq[held_n] = b;
			held_n = count;
			return;
		end
		pos = 0;
		k = 0;
		while (pos < count && k < 3) begin
			len = seq_len(pending[pos]);
			res[k].run_end = 1'b0;
			if (pending[pos] < CONT) begin
				res[k].code_point = CP_W'(pending[pos]);
				res[k].malformed  = 1'b0;
				res[k].bytes_used = LEN_1;
			end else if (len == LEN_1 || pos + len > count) begin
				// stray byte, or a lead cut short by end of text
				res[k].code_point = repl_cp;
				res[k].malformed  = 1'b1;
				res[k].bytes_used = LEN_1;
			end else begin
				broken = 1'b0;
				for (i = 1; i < len; i++)
					if ((pending[pos + i] & MASK_C0) != CONT)
						broken = 1'b1;
				case (len)
					LEN_2:   v = CP_W'(pending[pos][4:0]);
					LEN_3:   v = CP_W'(pending[pos][3:0]);
					default: v = CP_W'(pending[pos][2:0]);
				endcase
				for (i = 1; i < len; i++)
					v = (v << 6) | CP_W'(pending[pos + i][5:0]);
				res[k].code_point = broken ? repl_cp : v;
				res[k].malformed  = broken;
				res[k].bytes_used = LEN_W'(len);
			end
			pos += int'(res[k].bytes_used);
			k++;
		end
		res[k - 1].run_end = 1'b1;
		for (i = 0; i < k; i++)
			expected_cps = {expected_cps, res[i]};
		held_n = 0;
	endtask

	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		gap = $urandom_range(0, tx_idle_max);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= in_t'{text_byte: b, final_byte: fin};
		do @(posedge clk); while (in_stall);
		decode_byte(b, fin);
		bytes_sent++;
	endtask

	// drop valid, wait for every code point, then let the block finish off
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_cps.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_replacement(input logic [CP_W-1:0] value);
		settle();
		cfg_we   <= 1'b1;
		cfg_data <= value;
		repl_cp = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// one random sequence: mostly well-formed, some broken, some noise
	task automatic send_random_seq();
		logic [7:0] bytes [4];
		logic [7:0] junk;
		int         n, kind, i, slot;
		kind = $urandom_range(0, 15);
		n = 1;
		if (kind <= 4) begin
			bytes[0] = 8'($urandom_range(0, 127));
		end else if (kind <= 12) begin
			if (kind <= 7 || (kind == 12 && $urandom_range(0, 2) == 0)) begin
				n = 2;
				bytes[0] = LEAD_2 | 8'($urandom_range(0, 31));
			end else if (kind <= 9 || (kind == 12 && $urandom_range(0, 1) == 0)) begin
				n = 3;
				bytes[0] = LEAD_3 | 8'($urandom_range(0, 15));
			end else begin
				n = 4;
				bytes[0] = LEAD_4 | 8'($urandom_range(0, 7));
			end
			for (i = 1; i < n; i++)
				bytes[i] = CONT | 8'($urandom_range(0, 63));
			if (kind == 12) begin
				// bad continuation in a random slot
				slot = $urandom_range(1, n - 1);
				junk = 8'($urandom_range(0, 255));
				if ((junk & MASK_C0) == CONT)
					junk ^= 8'h40;
				bytes[slot] = junk;
			end
		end else if (kind == 13) begin
			bytes[0] = CONT | 8'($urandom_range(0, 63));
		end else if (kind == 14) begin
			bytes[0] = MASK_F8 | 8'($urandom_range(0, 7));
		end else begin
			bytes[0] = 8'($urandom_range(0, 255));
		end
		for (i = 0; i < n; i++)
			send_byte(bytes[i], $urandom_range(0, 29) == 0);
	endtask

	// result checker and receiver stall draw
	initial begin
		out_t want;
		logic bad;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles, %0d code points outstanding",
					cycle_count, expected_cps.size());
				$display("TEST FAILED");
				$finish;
			end
			if (arst_n && out_valid && !out_stall) begin
				rx_wait = $urandom_range(0, rx_idle_max);
				if (expected_cps.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: unexpected result cp=%h mal=%b used=%0d end=%b",
							$realtime, out_data.code_point, out_data.malformed,
							out_data.bytes_used, out_data.run_end);
				end else begin
					want = expected_cps.pop_front();
					bad = (out_data.code_point !== want.code_point)
						|| (out_data.malformed !== want.malformed)
						|| (out_data.bytes_used !== want.bytes_used)
						|| (out_data.run_end !== want.run_end);
					if (bad) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS)
							$display("%0t: mismatch exp cp=%h mal=%b used=%0d end=%b,",
								$realtime, want.code_point, want.malformed,
								want.bytes_used, want.run_end,
								" got cp=%h mal=%b used=%0d end=%b",
								out_data.code_point, out_data.malformed,
								out_data.bytes_used, out_data.run_end);
					end
					cps_checked++;
				end
			end
		end
	end

	// receiver: per-result wait, plus an optional long hold-off
	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (rx_wait > 0) begin
				rx_wait--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic test_reset_defaults();
		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'hC2, 1'b0);
		send_byte(8'hA9, 1'b0);
		send_byte(8'hE2, 1'b0);
		send_byte(8'h82, 1'b0);
		send_byte(8'hAC, 1'b0);
		// largest value a 4-byte form can carry
		send_byte(8'hF7, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hC3, 1'b0);
		send_byte(8'h41, 1'b0);
		// decodes to U+FFFD itself, not flagged
		send_byte(8'hEF, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBD, 1'b0);
		// text ends inside nested leads: three replacements
		send_byte(8'hF0, 1'b0);
		send_byte(8'hE2, 1'b0);
		send_byte(8'hC3, 1'b1);
		// cut short, then stray and ASCII replayed
		send_byte(8'hF0, 1'b0);
		send_byte(8'h9F, 1'b0);
		send_byte(8'h41, 1'b1);
		send_byte(8'h0A, 1'b1);
	endtask

	task automatic test_replacement_match();
		write_replacement(CP_W'(8'h41));
		send_byte(8'h80, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'hE1, 1'b1);
	endtask

	task automatic test_random_text(input int n_bytes, input logic [CP_W-1:0] repl,
			input int tx_max, input int rx_max);
		int stop_at;
		write_replacement(repl);
		tx_idle_max = tx_max;
		rx_idle_max = rx_max;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at)
			send_random_seq();
		send_byte(8'($urandom_range(0, 127)), 1'b1);
		tx_idle_max = 12;
		rx_idle_max = 12;
	endtask

	// receiver holds off while the sender keeps going, so the block backs up
	task automatic test_backpressure();
		int stop_at;
		settle();
		tx_idle_max = 0;
		hold_left = 300;
		stop_at = bytes_sent + 60;
		while (bytes_sent < stop_at)
			send_random_seq();
		send_byte(8'h2E, 1'b1);
		tx_idle_max = 12;
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		test_reset_defaults();
		test_replacement_match();
		test_random_text(150, '0, 12, 12);
		test_random_text(100, '1, 0, 0);
		test_random_text(150, CP_W'($urandom_range(0, 2097151)), 12, 12);
		test_backpressure();
		settle();
		$display("Sent %0d bytes, checked %0d code points across 5 replacement values;",
			bytes_sent, cps_checked);
		$display("covered truncation replay, bad continuations, stray bytes, back-pressure");
		if (mismatch_count == 0 && expected_cps.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ----- utf8_stream_decoder.f -----
design/utf8d_pkg.sv
design/utf8d_dp.sv
design/utf8d_ctrl.sv
design/utf8_stream_decoder.sv
test/testbench.sv
